// ===== rtl/sgd_pkg.sv =====
// shared constants, types and the derivative weight table for the
// savitzky-golay derivative filter; no dependencies
`timescale 1ns / 1ps

package sgd_pkg;

   localparam int HALF_WINDOW = 3;
   localparam int WIN         = 2 * HALF_WINDOW + 1;
   localparam int SAMPLE_W    = 16;
   localparam int WEIGHT_FRAC = 16;
   localparam int WEIGHT_W    = 18;
   localparam int PROD_W      = SAMPLE_W + WEIGHT_W;
   localparam int ACC_W       = 44;
   localparam int OUT_FRAC    = 8;
   localparam int RND_SHIFT   = WEIGHT_FRAC - OUT_FRAC;
   localparam int OUT_W       = 32;
   localparam int TAP_W       = 3;
   localparam int COUNT_W     = 3;

   // control of the shared multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic en;
   } sgd_mac_ctrl_type;

   // weight of window position row for evaluation column col, WEIGHT_FRAC fraction bits
   function automatic logic signed [WEIGHT_W-1:0] sgd_weight(
      input logic [TAP_W-1:0] col,
      input logic [TAP_W-1:0] row
   );
      logic signed [WEIGHT_W-1:0] w;
      case ({col, row})
         6'o00: w = -18'sd66836;
         6'o01: w =  18'sd31728;
         6'o02: w =  18'sd48112;
         6'o03: w =  18'sd18725;
         6'o04: w = -18'sd20025;
         6'o05: w = -18'sd31728;
         6'o06: w =  18'sd20025;
         6'o10: w = -18'sd31728;
         6'o11: w =  18'sd4421;
         6'o12: w =  18'sd16124;
         6'o13: w =  18'sd12483;
         6'o14: w =  18'sd2601;
         6'o15: w = -18'sd4421;
         6'o16: w =  18'sd520;
         6'o20: w = -18'sd7542;
         6'o21: w = -18'sd11963;
         6'o22: w = -18'sd4941;
         6'o23: w =  18'sd6242;
         6'o24: w =  18'sd14303;
         6'o25: w =  18'sd11963;
         6'o26: w = -18'sd8062;
         6'o30: w =  18'sd5721;
         6'o31: w = -18'sd17424;
         6'o32: w = -18'sd15084;
         6'o33: w =  18'sd0;
         6'o34: w =  18'sd15084;
         6'o35: w =  18'sd17424;
         6'o36: w = -18'sd5721;
         6'o40: w =  18'sd8062;
         6'o41: w = -18'sd11963;
         6'o42: w = -18'sd14303;
         6'o43: w = -18'sd6242;
         6'o44: w =  18'sd4941;
         6'o45: w =  18'sd11963;
         6'o46: w =  18'sd7542;
         6'o50: w = -18'sd520;
         6'o51: w =  18'sd4421;
         6'o52: w = -18'sd2601;
         6'o53: w = -18'sd12483;
         6'o54: w = -18'sd16124;
         6'o55: w = -18'sd4421;
         6'o56: w =  18'sd31728;
         6'o60: w = -18'sd20025;
         6'o61: w =  18'sd31728;
         6'o62: w =  18'sd20025;
         6'o63: w = -18'sd18725;
         6'o64: w = -18'sd48112;
         6'o65: w = -18'sd31728;
         6'o66: w =  18'sd66836;
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/sgd_mac.sv =====
// shared multiply-accumulate unit with round and saturate to q.8 output
// depends on sgd_pkg
`timescale 1ns / 1ps

module sgd_mac
   import sgd_pkg::*;
(
   input  logic                        clock,
   input  sgd_mac_ctrl_type            ctrl,
   input  logic signed [WEIGHT_W-1:0]  weight,
   input  logic signed [SAMPLE_W-1:0]  sample,
   output logic signed [OUT_W-1:0]     result
);

   localparam int SH_W = ACC_W - RND_SHIFT;

   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  rnd;
   logic signed [SH_W-1:0]   shifted;

   localparam logic signed [SH_W-1:0] OUT_MAX = SH_W'({1'b0, {(OUT_W-1){1'b1}}});
   localparam logic signed [SH_W-1:0] OUT_MIN = -OUT_MAX - SH_W'(1);

   assign prod = weight * sample;

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.en) begin
         if (ctrl.clear) begin
            acc_in = ACC_W'(prod);
         end else begin
            acc_in = acc_ff + ACC_W'(prod);
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // round half up, then floor shift
   assign rnd     = acc_ff + (ACC_W'(1) <<< (RND_SHIFT - 1));
   assign shifted = rnd[ACC_W-1:RND_SHIFT];

   always_comb begin
      if (shifted > OUT_MAX) begin
         result = OUT_MAX[OUT_W-1:0];
      end else if (shifted < OUT_MIN) begin
         result = OUT_MIN[OUT_W-1:0];
      end else begin
         result = shifted[OUT_W-1:0];
      end
   end

endmodule

// ===== rtl/savitzky_golay_derivative_filter.sv =====
// savitzky-golay first-derivative filter, 7-sample window, cubic fit
// items are taken only while idle; each result walks the 7 window taps through the one
// multiply-accumulate unit (S_MAC), then waits in S_DONE until the output register is
// free, so no new item is taken until the item's last result is handed off; a short
// segment goes straight to S_DONE, and an item with no result leaves the block idle
// reset: synchronous active-high, clears sequencer, sample count, window and output valid
`timescale 1ns / 1ps

module savitzky_golay_derivative_filter
   import sgd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic        req_tlast,   // segment_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] derivative
   output logic        rsp_tlast,   // run_last
   output logic        rsp_tuser    // [0] short_segment
);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;  // waiting for an item
   localparam logic [1:0] S_MAC  = 2'd1;  // one tap per cycle through the mac
   localparam logic [1:0] S_DONE = 2'd2;  // hand the result to the output register

   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(WIN);
   localparam logic [TAP_W-1:0]   TAP_LAST   = TAP_W'(WIN - 1);
   localparam logic [TAP_W-1:0]   COL_CENTER = TAP_W'(HALF_WINDOW);

   logic [1:0]                 state_ff, state_in;
   logic [TAP_W-1:0]           tap_ff, tap_in;
   logic [TAP_W-1:0]           col_ff, col_in;          // weight column of this result
   logic [TAP_W-1:0]           col_last_ff, col_last_in; // column of the item's last result
   logic                       short_ff, short_in;
   logic [COUNT_W-1:0]         seen_ff, seen_in;
   logic signed [SAMPLE_W-1:0] window_ff [WIN];         // oldest sample at index 0
   logic signed [SAMPLE_W-1:0] window_in [WIN];

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]           rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;
   logic                       rsp_short_ff, rsp_short_in;

   logic [COUNT_W-1:0]         seen_inc;
   logic                       window_full;
   logic                       first_full;
   logic                       final_result;
   sgd_mac_ctrl_type           mac_ctrl;
   logic signed [WEIGHT_W-1:0] mac_weight;
   logic signed [OUT_W-1:0]    mac_result;

   // shared multiply-accumulate: weight column col_ff against window tap tap_ff
   assign mac_weight = sgd_weight(col_ff, tap_ff);

   sgd_mac u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .weight (mac_weight),
      .sample (window_ff[tap_ff]),
      .result (mac_result)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_short_ff;

   // sample count saturates at the window length
   assign seen_inc     = (seen_ff < COUNT_FULL) ? seen_ff + COUNT_W'(1) : seen_ff;
   assign window_full  = (seen_inc == COUNT_FULL);
   assign first_full   = (seen_ff == COUNT_FULL - COUNT_W'(1));
   assign final_result = short_ff || (col_ff == col_last_ff);

   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      col_in       = col_ff;
      col_last_in  = col_last_ff;
      short_in     = short_ff;
      seen_in      = seen_ff;
      window_in    = window_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_short_in = rsp_short_ff;
      mac_ctrl     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               for (int j = 0; j < WIN - 1; j++) begin
                  window_in[j] = window_ff[j+1];
               end
               window_in[WIN-1] = req_tdata;
               // results run over consecutive columns: the leading columns once the
               // first window is complete, the centre column after that, and the
               // trailing columns at the end of the segment
               col_in      = first_full ? '0 : COL_CENTER;
               col_last_in = req_tlast ? TAP_LAST : COL_CENTER;
               short_in    = !window_full;
               seen_in     = req_tlast ? '0 : seen_inc;
               tap_in      = '0;
               if (window_full) begin
                  state_in = S_MAC;
               end else if (req_tlast) begin
                  state_in = S_DONE;   // short segment: one flagged zero result
               end
            end
         end
         S_MAC: begin
            mac_ctrl.en    = 1'b1;
            mac_ctrl.clear = (tap_ff == '0);
            if (tap_ff == TAP_LAST) begin
               state_in = S_DONE;
            end else begin
               tap_in = tap_ff + TAP_W'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = short_ff ? '0 : mac_result;
               rsp_last_in  = final_result;
               rsp_short_in = short_ff;
               if (final_result) begin
                  state_in = S_IDLE;
               end else begin
                  col_in   = col_ff + TAP_W'(1);
                  tap_in   = '0;
                  state_in = S_MAC;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         tap_ff       <= '0;
         for (int j = 0; j < WIN; j++) begin
            window_ff[j] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         tap_ff       <= tap_in;
         window_ff    <= window_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      col_last_ff  <= col_last_in;
      short_ff     <= short_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_short_ff <= rsp_short_in;
   end

   // a short-segment result is a lone zero item
   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_short_ff) |-> (rsp_data_ff == '0 && rsp_last_ff))
      else $error("short-segment result not a lone zero item");

   // the column walk never passes the item's last column
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAC) |-> (col_ff <= col_last_ff))
      else $error("weight column beyond the last column of the item");

   // the sample count never exceeds the window length
   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= COUNT_FULL)
      else $error("sample count above window length");

   // the last tap always leads to the result hand-off
   a_tap_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MAC && tap_ff == TAP_LAST) |=> (state_ff == S_DONE))
      else $error("mac walk did not end in result hand-off");

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for savitzky_golay_derivative_filter: a directed table,
// then random segments, each result checked against an in-bench slope predictor
// depends on rtl/sgd_pkg.sv and rtl/savitzky_golay_derivative_filter.sv
`timescale 1ns / 1ps

module testbench
   import sgd_pkg::*;
();

   // fit settings the block was built with
   localparam int POLY_FIT     = 3;
   localparam int SLOPE_ORDER  = 1;
   localparam int FIT_ORDER    = (POLY_FIT < 2 * HALF_WINDOW) ? POLY_FIT : 2 * HALF_WINDOW;
   localparam int COEF_FRAC    = 16;
   localparam int RANDOM_ITEMS = 200;
   localparam int DIRECTED_N   = 22;
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES  = 400;
   localparam longint LIMIT_CYCLES = 400000;

   // one expected result item
   typedef struct packed {
      logic signed [31:0] derivative;
      logic               run_last;
      logic               short_segment;
   } slope_result_type;

   // one stimulus row; typed rows carry a hand-written expectation instead
   typedef struct packed {
      logic signed [15:0] sample;
      logic               seg_end;
      logic               typed;
      logic [3:0]         typed_count;
      logic               typed_short;
   } stim_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [15:0] sample
   logic        req_tlast  = 1'b0; // segment_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] derivative
   logic        rsp_tlast;         // run_last
   logic        rsp_tuser;         // [0] short_segment

   // predictor state
   longint           slope_weight [WIN][WIN];   // [window position][evaluation column]
   int               window_samples [WIN];      // oldest first
   int               samples_seen;
   slope_result_type expected_slopes [$];

   int               errors        = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   int               hold_request  = 0;
   longint           cycle_count   = 0;
   slope_result_type oldest_slope;

   // directed table: lone sample, six-sample short segment, all-zero window,
   // then an eight-sample full-scale square wave (edge and interior columns)
   stim_row_type directed_rows [DIRECTED_N] = '{
      '{16'sh7fff, 1'b1, 1'b1, 4'd1, 1'b1},
      '{16'sh8000, 1'b0, 1'b1, 4'd0, 1'b0},
      '{16'sh7fff, 1'b0, 1'b1, 4'd0, 1'b0},
      '{16'shffff, 1'b0, 1'b1, 4'd0, 1'b0},
      '{16'sh0000, 1'b0, 1'b1, 4'd0, 1'b0},
      '{16'sh0001, 1'b0, 1'b1, 4'd0, 1'b0},
      '{16'sh5a5a, 1'b1, 1'b1, 4'd1, 1'b1},
      '{16'sh0000, 1'b0, 1'b1, 4'd0, 1'b0},
      '{16'sh0000, 1'b0, 1'b1, 4'd0, 1'b0},
      '{16'sh0000, 1'b0, 1'b1, 4'd0, 1'b0},
      '{16'sh0000, 1'b0, 1'b1, 4'd0, 1'b0},
      '{16'sh0000, 1'b0, 1'b1, 4'd0, 1'b0},
      '{16'sh0000, 1'b0, 1'b1, 4'd0, 1'b0},
      '{16'sh0000, 1'b1, 1'b1, 4'd7, 1'b0},
      '{16'sh7fff, 1'b0, 1'b1, 4'd0, 1'b0},
      '{16'sh8000, 1'b0, 1'b1, 4'd0, 1'b0},
      '{16'sh7fff, 1'b0, 1'b1, 4'd0, 1'b0},
      '{16'sh8000, 1'b0, 1'b1, 4'd0, 1'b0},
      '{16'sh7fff, 1'b0, 1'b1, 4'd0, 1'b0},
      '{16'sh8000, 1'b0, 1'b1, 4'd0, 1'b0},
      '{16'sh7fff, 1'b0, 1'b0, 4'd0, 1'b0},
      '{16'sh8000, 1'b1, 1'b0, 4'd0, 1'b0}
   };

   savitzky_golay_derivative_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint gcd_of(longint a, longint b);
      longint r;
      while (b != 0) begin
         r = a % b;
         a = b;
         b = r;
      end
      return a;
   endfunction

   function automatic longint abs_of(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // scaled gram polynomial of the given order at point t, and its derivatives
   function automatic longint gram_scaled(longint t, int order, int deriv);
      longint q [0:POLY_FIT][0:SLOPE_ORDER];
      longint m2;
      longint v;
      longint tprev;
      m2 = 2 * HALF_WINDOW;
      for (int s = 0; s <= SLOPE_ORDER; s++)
         q[0][s] = (s == 0) ? 1 : 0;
      for (int k = 1; k <= FIT_ORDER; k++) begin
         tprev = (k == 1) ? 1 : longint'(k - 1) * (m2 - (k - 1) + 1);
         for (int s = 0; s <= SLOPE_ORDER; s++) begin
            v = t * q[k - 1][s];
            if (s > 0)
               v += longint'(s) * q[k - 1][s - 1];
            v *= longint'(4 * k - 2);
            if (k >= 2)
               v -= longint'(k - 1) * (m2 + k) * tprev * q[k - 2][s];
            q[k][s] = v;
         end
      end
      return q[order][deriv];
   endfunction

   // exact rational weights, then rounded to COEF_FRAC bits, ties away from zero
   function automatic void build_slope_weights();
      longint m2, num, den, dk, kf, g2, tn, td, g, mag, w;
      m2 = 2 * HALF_WINDOW;
      for (int d = 0; d < WIN; d++) begin
         for (int e = 0; e < WIN; e++) begin
            num = 0;
            den = 1;
            dk  = 1;
            kf  = 1;
            g2  = m2 + 1;
            for (int k = 0; k <= FIT_ORDER; k++) begin
               if (k > 0) begin
                  dk *= longint'(k) * (m2 - k + 1);
                  kf *= k;
                  g2 *= m2 + k + 1;
               end
               tn = longint'(2 * k + 1) * gram_scaled(d - HALF_WINDOW, k, 0);
               td = dk * kf * g2;
               g  = gcd_of(abs_of(tn), td);
               tn /= g;
               td /= g;
               tn *= gram_scaled(e - HALF_WINDOW, k, SLOPE_ORDER);
               g  = gcd_of(abs_of(tn), td);
               tn /= g;
               td /= g;
               g   = gcd_of(den, td);
               num = num * (td / g) + tn * (den / g);
               den = (den / g) * td;
               g   = gcd_of(abs_of(num), den);
               num /= g;
               den /= g;
            end
            mag = abs_of(num) * (longint'(1) << COEF_FRAC);
            w   = (2 * mag + den) / (2 * den);
            slope_weight[d][e] = (num < 0) ? -w : w;
         end
      end
   endfunction

   // weighted window sum for one column, to 8 fraction bits, round half up, saturate
   function automatic slope_result_type column_slope(int col);
      slope_result_type r;
      longint acc;
      acc = 0;
      for (int j = 0; j < WIN; j++)
         acc += slope_weight[j][col] * longint'(window_samples[j]);
      acc += longint'(1) << (COEF_FRAC - 9);
      acc = acc >>> (COEF_FRAC - 8);
      if (acc > 64'sd2147483647)
         acc = 64'sd2147483647;
      if (acc < -64'sd2147483648)
         acc = -64'sd2147483648;
      r.derivative    = acc[31:0];
      r.run_last      = 1'b0;
      r.short_segment = 1'b0;
      return r;
   endfunction

   // advance the predictor by one accepted item and queue the results it causes
   function automatic void predict_slopes(logic signed [15:0] smp, logic seg_end);
      slope_result_type made [$];
      slope_result_type r;
      int prev;
      prev = samples_seen;
      for (int j = 0; j + 1 < WIN; j++)
         window_samples[j] = window_samples[j + 1];
      window_samples[WIN - 1] = int'(smp);
      if (samples_seen < WIN)
         samples_seen++;
      if (samples_seen >= WIN) begin
         // first full window releases the leading edge samples at once
         if (prev + 1 == WIN) begin
            for (int c = 0; c <= HALF_WINDOW; c++)
               made = {made, column_slope(c)};
         end else begin
            made = {made, column_slope(HALF_WINDOW)};
         end
      end
      if (seg_end) begin
         if (samples_seen < WIN) begin
            r = '0;
            r.short_segment = 1'b1;
            made = {made, r};
         end else begin
            for (int c = HALF_WINDOW + 1; c < WIN; c++)
               made = {made, column_slope(c)};
         end
         samples_seen = 0;
      end
      if (made.size() > 0)
         made[made.size() - 1].run_last = 1'b1;
      foreach (made[i])
         expected_slopes = {expected_slopes, made[i]};
   endfunction

   // offer one item, hold it until taken, then predict and maybe idle a while
   task automatic send_item(input stim_row_type row);
      int mark;
      slope_result_type r;
      req_tvalid <= 1'b1;
      req_tdata  <= row.sample;
      req_tlast  <= row.seg_end;
      do @(posedge clock); while (!req_tready);
      mark = expected_slopes.size();
      predict_slopes(row.sample, row.seg_end);
      if (row.typed) begin
         // hand-written expectation replaces the predicted one
         while (expected_slopes.size() > mark)
            void'(expected_slopes.pop_back());
         for (int i = 0; i < row.typed_count; i++) begin
            r = '0;
            r.run_last      = (i == row.typed_count - 1);
            r.short_segment = row.typed_short;
            expected_slopes = {expected_slopes, r};
         end
      end
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
      end
   endtask

   // sender pause: nothing is offered until every expected result is back
   task automatic wait_results_drained();
      while (expected_slopes.size() != 0)
         @(posedge clock);
   endtask

   // one random sample in the given style for position idx of a segment
   function automatic logic signed [15:0] pick_sample(int style, int idx, int base, int slope);
      logic [31:0] raw;
      int v;
      raw = $urandom;
      case (style)
         0: v = int'(raw[15:0]);
         1: v = base + slope * idx + int'($urandom_range(16)) - 8;
         2: v = idx[0] ? 32767 : -32768;
         default: begin
            case ($urandom_range(4))
               0: v = 32767;
               1: v = -32768;
               2: v = -1;
               3: v = 1;
               default: v = 0;
            endcase
         end
      endcase
      return v[15:0];
   endfunction

   // receiver: random stalls, or a long hold-off when asked
   initial begin
      int held;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            held = hold_request;
            hold_request = 0;
            rsp_tready <= 1'b0;
            repeat (held) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // checker: every result taken is compared with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_slopes.size() == 0) begin
            $display("%0t: unexpected result: derivative %0d last %0b short %0b",
                     $time, $signed(rsp_tdata), rsp_tlast, rsp_tuser);
            errors++;
         end else begin
            oldest_slope = expected_slopes.pop_front();
            if (rsp_tdata !== oldest_slope.derivative) begin
               $display("%0t: derivative mismatch: expected %0d actual %0d",
                        $time, oldest_slope.derivative, $signed(rsp_tdata));
               errors++;
            end
            if (rsp_tlast !== oldest_slope.run_last) begin
               $display("%0t: run_last mismatch: expected %0b actual %0b",
                        $time, oldest_slope.run_last, rsp_tlast);
               errors++;
            end
            if (rsp_tuser !== oldest_slope.short_segment) begin
               $display("%0t: short_segment mismatch: expected %0b actual %0b",
                        $time, oldest_slope.short_segment, rsp_tuser);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d results still expected", $time,
                  expected_slopes.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      int sent;
      int phase;
      int seg_len;
      int style;
      int base;
      int slope;
      int pick;

      build_slope_weights();
      foreach (window_samples[j])
         window_samples[j] = 0;
      samples_seen = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, sender idles lightly and receiver stalls heavily
      send_idle_pct = 14;
      recv_idle_pct = 83;
      for (int i = 0; i < DIRECTED_N; i++)
         send_item(directed_rows[i]);

      // random segments in three idling phases
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent * 3 / RANDOM_ITEMS > phase) begin
            phase = sent * 3 / RANDOM_ITEMS;
            req_tvalid <= 1'b0;
            @(posedge clock);
            wait_results_drained();
            if (phase == 1) begin
               send_idle_pct = 83;
               recv_idle_pct = 14;
            end else begin
               // no idling, but one long receiver hold-off to back the block up
               send_idle_pct = 0;
               recv_idle_pct = 0;
               hold_request  = HOLD_CYCLES;
            end
         end
         pick = $urandom_range(99);
         if (pick < 15)
            seg_len = $urandom_range(WIN - 1, 1);
         else if (pick < 25)
            seg_len = WIN;
         else if (pick < 88)
            seg_len = $urandom_range(16, WIN + 1);
         else
            seg_len = $urandom_range(36, 20);
         style = $urandom_range(3);
         base  = int'($urandom_range(65535)) - 32768;
         slope = int'($urandom_range(600)) - 300;
         for (int k = 0; k < seg_len; k++) begin
            row = '0;
            row.sample  = pick_sample(style, k, base, slope);
            row.seg_end = (k == seg_len - 1);
            send_item(row);
            sent++;
         end
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
